// File: rtl/core/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg: shared types and constants of the exponential intensity transform
// Pixel word types, register index codes, pipeline sizes and the constant
// threshold table ceil(65536 * ln(m)) that the search stages compare against.
// ----------------------------------------------------------------------------
package pet_pkg;

  // Channel and arithmetic widths
  localparam int ChanW   = 8;
  localparam int ScaleW  = 24;
  localparam int ProdW   = ChanW + ScaleW;
  localparam int ThrW    = 19;
  localparam int Entries = 1 << ChanW;

  // Search over the result bits, a fixed number of bits per stage
  localparam int StageBits    = 2;
  localparam int SearchStages = ChanW / StageBits;
  // Product register plus the search stages
  localparam int Latency      = SearchStages + 1;

  // ln(2) in unsigned Q0.64, truncated
  localparam logic [63:0] Ln2Q64 = 64'hB17217F7D1CF79AB;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INV_SCALE = 2'd0,
    CFG_RED_EN    = 2'd1,
    CFG_GREEN_EN  = 2'd2,
    CFG_BLUE_EN   = 2'd3
  } pet_cfg_idx_e;

  // Input pixel word
  typedef struct packed {
    logic [ChanW-1:0] red_value;
    logic [ChanW-1:0] green_value;
    logic [ChanW-1:0] blue_value;
  } pet_pix_in_t;

  // Result pixel word
  typedef struct packed {
    logic [ChanW-1:0] red_result;
    logic [ChanW-1:0] green_result;
    logic [ChanW-1:0] blue_result;
  } pet_pix_out_t;

  // Entry j holds ceil(65536 * ln(j + 1)); entry 0 is never read
  typedef logic [Entries-1:0][ThrW-1:0] pet_thr_tab_t;

  // Build the table at elaboration: bitwise log2 by repeated squaring of a
  // Q2.62 mantissa, then scale by ln(2) and round up to 16 fraction bits.
  function automatic pet_thr_tab_t pet_build_thr();
    pet_thr_tab_t  tab;
    logic [63:0]   y;
    logic [127:0]  sq;
    logic [55:0]   lg;
    logic [127:0]  prod;
    int            m;
    int            e;
    tab = '0;
    for (int j = 1; j < Entries; j++) begin
      m = j + 1;
      e = 0;
      for (int k = 1; k <= ChanW; k++) begin
        if (m >= (1 << k)) begin
          e = k;
        end
      end
      y  = 64'(m) << (62 - e);
      lg = '0;
      lg[55:52] = 4'(e);
      for (int b = 51; b >= 0; b--) begin
        sq = {64'd0, y} * {64'd0, y};
        y  = sq[125:62];
        if (y[63]) begin
          lg[b] = 1'b1;
          y     = y >> 1;
        end
      end
      prod   = {72'd0, lg} * {64'd0, Ln2Q64};
      tab[j] = ThrW'((prod + ((128'd1 << 100) - 128'd1)) >> 100);
    end
    return tab;
  endfunction

  localparam pet_thr_tab_t ThrTab = pet_build_thr();

endpackage

// File: rtl/core/pixel_exponential_transform.sv
// ----------------------------------------------------------------------------
// pixel_exponential_transform: exponential intensity transform on RGB pixels
// Takes one pixel word per cycle and returns floor(e^x) - 1 per enabled
// channel, with x = v * inverse_scale / 2^16, saturating at 255.
// ----------------------------------------------------------------------------
// A pixel word is taken at every clock edge where start is high; busy stays
// low, so the block accepts one word each cycle with no gaps. Each word comes
// back on result_o flagged by result_strobe_o for one cycle; the receiver
// cannot stall it. The pipeline is one multiply stage (8 x 24 bit product)
// plus four search stages, each resolving two result bits against a constant
// 256-entry threshold table. Configuration writes take effect at once and
// belong to idle periods.
module pixel_exponential_transform (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  pet_pkg::pet_pix_in_t   pixel_i,
  output logic                   result_strobe_o,
  output pet_pkg::pet_pix_out_t  result_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [pet_pkg::ScaleW-1:0] cfg_wdata_i
);
  import pet_pkg::*;

  logic [ScaleW-1:0] inv_scale_q;
  logic              red_en_q;
  logic              green_en_q;
  logic              blue_en_q;
  logic [Latency-1:0] vld_q;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Write configuration registers; the enable registers keep only bit 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_scale_q <= ScaleW'(1425);
      red_en_q    <= 1'b1;
      green_en_q  <= 1'b1;
      blue_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (pet_cfg_idx_e'(cfg_idx_i))
        CFG_INV_SCALE: inv_scale_q <= cfg_wdata_i;
        CFG_RED_EN:    red_en_q    <= cfg_wdata_i[0];
        CFG_GREEN_EN:  green_en_q  <= cfg_wdata_i[0];
        CFG_BLUE_EN:   blue_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Carry the valid bit alongside the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept};
    end
  end

  assign result_strobe_o = vld_q[Latency-1];

  pet_channel u_red (
    .clk_i      (clk_i),
    .in_value_i (pixel_i.red_value),
    .en_i       (red_en_q),
    .scale_i    (inv_scale_q),
    .result_o   (result_o.red_result)
  );

  pet_channel u_green (
    .clk_i      (clk_i),
    .in_value_i (pixel_i.green_value),
    .en_i       (green_en_q),
    .scale_i    (inv_scale_q),
    .result_o   (result_o.green_result)
  );

  pet_channel u_blue (
    .clk_i      (clk_i),
    .in_value_i (pixel_i.blue_value),
    .en_i       (blue_en_q),
    .scale_i    (inv_scale_q),
    .result_o   (result_o.blue_result)
  );

  // Every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(Latency) result_strobe_o)
    else $error("accepted word did not appear after the pipeline latency");

  // A disabled channel returns its input value unchanged
  a_red_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !$past(red_en_q, Latency))
    |-> (result_o.red_result == $past(pixel_i.red_value, Latency)))
    else $error("disabled red channel did not pass its value through");

  // A zero scale gives x = 0 and a zero result on an enabled channel
  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && $past(green_en_q, Latency)
     && ($past(inv_scale_q, Latency) == '0))
    |-> (result_o.green_result == '0))
    else $error("zero scale produced a nonzero green result");

endmodule

// File: rtl/core/pet_channel.sv
// ----------------------------------------------------------------------------
// pet_channel: one color channel of the exponential transform
// Registers v * inverse_scale, then finds the count of thresholds reached by
// a pipelined binary search, two result bits per stage, and muxes in the
// raw value when the channel is disabled.
// ----------------------------------------------------------------------------
module pet_channel (
  input  logic                        clk_i,
  input  logic [pet_pkg::ChanW-1:0]   in_value_i,
  input  logic                        en_i,
  input  logic [pet_pkg::ScaleW-1:0]  scale_i,
  output logic [pet_pkg::ChanW-1:0]   result_o
);
  import pet_pkg::*;

  logic [ProdW-1:0] p_q   [SearchStages];
  logic [ChanW-1:0] cnt_q [SearchStages];
  logic [ChanW-1:0] v_q   [SearchStages];
  logic             en_q  [SearchStages];
  logic [ChanW-1:0] cnt_d [SearchStages];
  logic [ChanW-1:0] res_q;

  // Decide the next result bits of every stage, most significant first
  always_comb begin
    logic [ChanW-1:0] c;
    logic [ChanW-1:0] cand;
    logic [2:0]       bi;
    for (int s = 0; s < SearchStages; s++) begin
      c = cnt_q[s];
      for (int b = 0; b < StageBits; b++) begin
        bi       = 3'(ChanW - 1 - s * StageBits - b);
        cand     = c;
        cand[bi] = 1'b1;
        if ({{(ProdW-ThrW){1'b0}}, ThrTab[cand]} <= p_q[s]) begin
          c = cand;
        end
      end
      cnt_d[s] = c;
    end
  end

  // Advance the data stages every cycle
  always_ff @(posedge clk_i) begin
    p_q[0]   <= {{ScaleW{1'b0}}, in_value_i} * {{ChanW{1'b0}}, scale_i};
    cnt_q[0] <= '0;
    v_q[0]   <= in_value_i;
    en_q[0]  <= en_i;
    for (int s = 1; s < SearchStages; s++) begin
      p_q[s]   <= p_q[s-1];
      cnt_q[s] <= cnt_d[s-1];
      v_q[s]   <= v_q[s-1];
      en_q[s]  <= en_q[s-1];
    end
    res_q <= en_q[SearchStages-1] ? cnt_d[SearchStages-1] : v_q[SearchStages-1];
  end

  assign result_o = res_q;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pixel_exponential_transform
// Drives pixel words through the command port across several register
// settings and idle patterns. A threshold-counting predictor built from an
// integer ln series works out each result word but for directed rows that
// carry a literal result. The monitor checks the result words in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pet_pkg::*;

  // Directed stimulus row: register setting, pixel word, optional literal result
  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [2:0]        en;     // red, green, blue
    pet_pix_in_t       pix;
    logic              lit;
    pet_pix_out_t      want;
  } dir_row_t;

  localparam int DirCount = 19;
  localparam dir_row_t DirRows [DirCount] = '{
    '{24'd1425,     3'b111, 24'h000000, 1'b1, 24'h000000},
    '{24'd1425,     3'b111, 24'hFFFFFF, 1'b0, 24'h000000},
    '{24'd1425,     3'b111, 24'h0180FE, 1'b0, 24'h000000},
    '{24'd1425,     3'b111, 24'h7F8040, 1'b0, 24'h000000},
    '{24'd0,        3'b111, 24'hFFAA55, 1'b1, 24'h000000},
    '{24'd0,        3'b000, 24'hFFAA55, 1'b1, 24'hFFAA55},
    '{24'hFFFFFF,   3'b111, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{24'hFFFFFF,   3'b111, 24'h010280, 1'b1, 24'hFFFFFF},
    '{24'hFFFFFF,   3'b111, 24'h000100, 1'b1, 24'h00FF00},
    '{24'hFFFFFF,   3'b101, 24'h014DFF, 1'b1, 24'hFF4DFF},
    '{24'd65536,    3'b111, 24'h050604, 1'b0, 24'h000000},
    '{24'd65536,    3'b010, 24'hAA55FF, 1'b0, 24'h000000},
    '{24'd1,        3'b111, 24'hFFFFFF, 1'b1, 24'h000000},
    '{24'd1425,     3'b100, 24'hC86432, 1'b0, 24'h000000},
    '{24'd363409,   3'b111, 24'h010002, 1'b0, 24'h000000},
    '{24'd363408,   3'b111, 24'h010002, 1'b0, 24'h000000},
    '{24'd45427,    3'b111, 24'h010101, 1'b0, 24'h000000},
    '{24'd45426,    3'b111, 24'h010101, 1'b0, 24'h000000},
    '{24'd1425,     3'b011, 24'hFF00FF, 1'b0, 24'h000000}
  };

  localparam int RandPhases     = 10;
  localparam int ItemsPerPhase  = 115;
  localparam int IdlePct [4]    = '{0, 74, 0, 32};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  pet_pix_in_t        pixel_i     = '0;
  logic               result_strobe_o;
  pet_pix_out_t       result_o;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_idx_i   = CFG_INV_SCALE;
  logic [ScaleW-1:0]  cfg_wdata_i = '0;

  // Register copies as the block should hold them
  logic [ScaleW-1:0]  scale_r = 24'd1425;
  logic [2:0]         en_r    = 3'b111;

  // ceil(65536 * ln(m)) for m = 2..256
  longint unsigned    ln_thresh [2:256];

  pet_pix_out_t       expected_pixels [$];
  pet_pix_out_t       due_pixel;
  int                 mismatch_cnt = 0;
  bit                 sending = 1'b0;

  pixel_exponential_transform dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .pixel_i         (pixel_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Free-running clock, period 12
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // atanh(1/q) in Q.56 by its power series
  function automatic longint unsigned atanh_inv_q56(longint unsigned q);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned div;
    longint unsigned q_sq;
    term = (64'd1 << 56) / q;
    sum  = 0;
    div  = 1;
    q_sq = q * q;
    while (term != 0) begin
      sum  += term / div;
      term /= q_sq;
      div  += 2;
    end
    return sum;
  endfunction

  // Accumulate ln(m) = ln(m-1) + 2*atanh(1/(2m-1)), round up to 16 fraction bits
  function automatic void build_ln_thresh();
    longint unsigned ln_acc;
    longint unsigned round_up;
    ln_acc   = 0;
    round_up = (64'd1 << 40) - 1;
    for (int m = 2; m <= 256; m++) begin
      ln_acc += 2 * atanh_inv_q56(longint'(2 * m - 1));
      ln_thresh[m] = (ln_acc + round_up) >> 40;
    end
  endfunction

  // One channel: count thresholds reached by v * scale, or pass v through
  function automatic logic [7:0] exp_level(logic [7:0] v, logic en);
    longint unsigned prod;
    int              level;
    if (!en) begin
      return v;
    end
    prod  = longint'(v) * longint'(scale_r);
    level = 0;
    for (int m = 2; m <= 256; m++) begin
      if (prod >= ln_thresh[m]) begin
        level++;
      end else begin
        break;
      end
    end
    if (level > 255) begin
      level = 255;
    end
    return 8'(level);
  endfunction

  function automatic pet_pix_out_t exp_pixel(pet_pix_in_t pix);
    pet_pix_out_t res;
    res.red_result   = exp_level(pix.red_value,   en_r[2]);
    res.green_result = exp_level(pix.green_value, en_r[1]);
    res.blue_result  = exp_level(pix.blue_value,  en_r[0]);
    return res;
  endfunction

  // Random channel level, weighted toward the extremes
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 8'd255;
      1: return 8'd0;
      2: return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Hold a pixel word on the port until accepted, then record its result
  task automatic send_pixel(pet_pix_in_t pix, logic lit, pet_pix_out_t lit_out);
    start   <= 1'b1;
    pixel_i <= pix;
    sending  = 1'b1;
    do @(posedge clk_i); while (busy);
    if (lit) begin
      expected_pixels.push_back(lit_out);
    end else begin
      expected_pixels.push_back(exp_pixel(pix));
    end
  endtask

  // Drop start, with noise on the pixel port
  task automatic stop_sending();
    if (sending) begin
      start   <= 1'b0;
      pixel_i <= pet_pix_in_t'($urandom());
      sending  = 1'b0;
    end
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      stop_sending();
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every result word is back
  task automatic drain_results();
    stop_sending();
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers; enable writes carry junk in the upper bits
  task automatic write_setting(logic [ScaleW-1:0] scale, logic [2:0] en);
    pet_cfg_idx_e      en_idx [3] = '{CFG_RED_EN, CFG_GREEN_EN, CFG_BLUE_EN};
    logic [ScaleW-1:0] wd;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_INV_SCALE;
    cfg_wdata_i <= scale;
    @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      wd          = ScaleW'($urandom());
      wd[0]       = en[2 - i];
      cfg_idx_i   <= en_idx[i];
      cfg_wdata_i <= wd;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    scale_r   = scale;
    en_r      = en;
  endtask

  // Gap after a word: geometric, idle_pct percent of cycles on average
  function automatic int pick_gap(int idle_pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) begin
      gap++;
    end
    return gap;
  endfunction

  function automatic logic [ScaleW-1:0] pick_scale(int phase);
    case (phase)
      0: return 24'hFFFFFF;
      1: return 24'd0;
      2: return 24'd1;
      3: return 24'd1425;
      default: begin
        case ($urandom_range(0, 3))
          0: return ScaleW'($urandom_range(1, 2000));
          1: return ScaleW'($urandom_range(1400, 1450));
          2: return ScaleW'($urandom());
          default: return ScaleW'($urandom_range(2000, 70000));
        endcase
      end
    endcase
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_pixels.size() == 0) begin
        $error("result word %h with nothing expected", result_o);
        mismatch_cnt++;
      end else begin
        due_pixel = expected_pixels.pop_front();
        if (result_o.red_result !== due_pixel.red_result) begin
          $error("red_result expected %0d actual %0d",
                 due_pixel.red_result, result_o.red_result);
          mismatch_cnt++;
        end
        if (result_o.green_result !== due_pixel.green_result) begin
          $error("green_result expected %0d actual %0d",
                 due_pixel.green_result, result_o.green_result);
          mismatch_cnt++;
        end
        if (result_o.blue_result !== due_pixel.blue_result) begin
          $error("blue_result expected %0d actual %0d",
                 due_pixel.blue_result, result_o.blue_result);
          mismatch_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    pet_pix_in_t pix;
    int          idle_pct;
    build_ln_thresh();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, reprogramming only between rows with another setting
    for (int r = 0; r < DirCount; r++) begin
      if (DirRows[r].scale != scale_r || DirRows[r].en != en_r) begin
        drain_results();
        write_setting(DirRows[r].scale, DirRows[r].en);
      end
      send_pixel(DirRows[r].pix, DirRows[r].lit, DirRows[r].want);
      idle_for($urandom_range(0, 2));
    end

    // Random phases, each with its own setting and idle pattern
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_results();
      write_setting(pick_scale(ph), 3'($urandom()));
      idle_pct = IdlePct[ph % 4];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pix.red_value   = pick_level();
        pix.green_value = pick_level();
        pix.blue_value  = pick_level();
        send_pixel(pix, 1'b0, '0);
        if (ph == 5 && n == 60) begin
          drain_results();
        end else begin
          idle_for(pick_gap(idle_pct));
        end
      end
    end

    drain_results();
    repeat (Latency + 2) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $error("%0d result words never arrived", expected_pixels.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("pixel_exponential_transform verification clean");
    end else begin
      $display("pixel_exponential_transform verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 400000);
    $display("pixel_exponential_transform verification failed");
    $finish;
  end

endmodule
